// File: sv/dns_query_a_record_responder_core_macros.svh
// Assertion macros used by the DNS responder back end.
`ifndef DNS_QUERY_A_RECORD_RESPONDER_CORE_MACROS_SVH
`define DNS_QUERY_A_RECORD_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define DQAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define DQAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dqar_pkg.sv
// Types and constants of the DNS query A-record responder.
`timescale 1ns / 1ps
`default_nettype none
package dqar_pkg;

  localparam int HDR_LEN     = 12;
  localparam int ANS_LEN     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_W       = 10;

  localparam logic [15:0] TYPE_A   = 16'h0001;
  localparam logic [7:0]  FLAGS_HI = 8'h81;
  localparam logic [7:0]  FLAGS_LO = 8'h80;

  localparam logic [1:0] VERDICT_COLLECT = 2'd0;
  localparam logic [1:0] VERDICT_READY   = 2'd1;
  localparam logic [1:0] VERDICT_DROP    = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       last;
    logic [8:0] read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [LEN_W-1:0] reply_length;
    logic [7:0]       reply_byte;
    logic             is_a_answer;
  } resp_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PUSH_LAST,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } cmd_t;

  // Fixed head of the A answer: name pointer, type, class, TTL, rdlength.
  function automatic logic [7:0] ans_head(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'h0C;
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h01;
      4'd9:    b = 8'h3C;
      4'd11:   b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: sv/dqar_front.sv
// Front end: takes commands and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module dqar_front
  import dqar_pkg::*;
(
  input  wire logic start,
  input  wire req_t request,
  input  wire logic queue_full,
  output logic      busy,
  output logic      enq,
  output cmd_t      enq_cmd
);

  assign busy = queue_full;
  assign enq  = start && !queue_full;

  always_comb begin
    enq_cmd.data_byte  = request.data_byte;
    enq_cmd.read_index = request.read_index;
    priority if (request.command) begin
      enq_cmd.op = OP_READ;
    end else if (request.last) begin
      enq_cmd.op = OP_PUSH_LAST;
    end else begin
      enq_cmd.op = OP_PUSH;
    end
  end

endmodule
`default_nettype wire

// File: sv/dqar_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module dqar_queue
  import dqar_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enq,
  input  wire cmd_t enq_cmd,
  input  wire logic deq,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t       entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(QUEUE_DEPTH));
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({enq, deq})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/dqar_back.sv
// Back end: query parser, byte store and reply generator.
`timescale 1ns / 1ps
`default_nettype none
module dqar_back
  import dqar_pkg::*;
#(
  parameter int MAX_PACKET = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire cmd_t        item,
  output logic             item_pop,
  input  wire logic [31:0] answer_ipv4,
  output logic             done,
  output resp_t            response
);

  `include "dns_query_a_record_responder_core_macros.svh"

  localparam int AW = $clog2(MAX_PACKET);
  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int LW = $clog2(MAX_PACKET + 257);
  localparam int QW = CW + 1;
  localparam int XW = (QW > 9) ? QW : 9;

  // Parse state
  logic [CW-1:0] byte_count,        byte_count_next;
  logic [LW-1:0] next_label_offset, next_label_offset_next;
  logic          name_terminated,   name_terminated_next;
  logic [CW-1:0] name_end_offset,   name_end_offset_next;
  logic [15:0]   query_type,        query_type_next;
  logic [1:0]    packet_verdict,    packet_verdict_next;
  logic [CW-1:0] question_end,      question_end_next;

  logic [7:0]    mem [MAX_PACKET];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_rdata;

  logic [CW-1:0] pos;
  logic [QW-1:0] qend_w;
  logic [QW-1:0] need;
  logic [QW-1:0] rlen;
  logic [XW-1:0] idx;
  logic [3:0]    ans_k;
  logic          is_a;

  resp_t         res;
  logic          sel_mem;
  resp_t         res_q;
  logic          sel_mem_q;

  assign item_pop = item_valid;

  always_comb begin
    byte_count_next        = byte_count;
    next_label_offset_next = next_label_offset;
    name_terminated_next   = name_terminated;
    name_end_offset_next   = name_end_offset;
    query_type_next        = query_type;
    packet_verdict_next    = packet_verdict;
    question_end_next      = question_end;
    mem_we    = 1'b0;
    mem_waddr = '0;
    pos       = '0;
    qend_w    = '0;
    need      = '0;
    rlen      = '0;
    idx       = '0;
    ans_k     = '0;
    is_a      = 1'b0;
    res       = '0;
    sel_mem   = 1'b0;

    if (item_valid && item.op == OP_READ) begin
      is_a = (query_type == TYPE_A);
      if (packet_verdict == VERDICT_READY) begin
        rlen = QW'(question_end) + (is_a ? QW'(ANS_LEN) : QW'(0));
      end
      idx = XW'(item.read_index);
      ans_k = 4'(idx - XW'(question_end));
      res.verdict      = packet_verdict;
      res.reply_length = LEN_W'(rlen);
      res.is_a_answer  = (packet_verdict == VERDICT_READY) && is_a;
      if (packet_verdict == VERDICT_READY && idx < XW'(rlen)) begin
        if (idx < XW'(question_end)) begin
          // Patch flags and counts, echo everything else
          unique case (idx)
            XW'(2):  res.reply_byte = FLAGS_HI;
            XW'(3):  res.reply_byte = FLAGS_LO;
            XW'(4):  res.reply_byte = 8'h00;
            XW'(5):  res.reply_byte = 8'h01;
            XW'(6):  res.reply_byte = 8'h00;
            XW'(7):  res.reply_byte = {7'd0, is_a};
            XW'(8), XW'(9), XW'(10), XW'(11): res.reply_byte = 8'h00;
            default: sel_mem = 1'b1;
          endcase
        end else if (ans_k < 4'(HDR_LEN)) begin
          res.reply_byte = ans_head(ans_k);
        end else begin
          unique case (ans_k[1:0])
            2'd0: res.reply_byte = answer_ipv4[31:24];
            2'd1: res.reply_byte = answer_ipv4[23:16];
            2'd2: res.reply_byte = answer_ipv4[15:8];
            2'd3: res.reply_byte = answer_ipv4[7:0];
          endcase
        end
      end
    end else if (item_valid) begin
      // A push after a verdict opens a new query
      if (packet_verdict != VERDICT_COLLECT) begin
        packet_verdict_next    = VERDICT_COLLECT;
        question_end_next      = '0;
        query_type_next        = '0;
        name_end_offset_next   = '0;
        byte_count_next        = '0;
        next_label_offset_next = LW'(HDR_LEN);
        name_terminated_next   = 1'b0;
      end

      if (byte_count_next < CW'(MAX_PACKET)) begin
        pos             = byte_count_next;
        mem_we          = 1'b1;
        mem_waddr       = AW'(pos);
        byte_count_next = pos + CW'(1);
        if (!name_terminated_next) begin
          if (pos >= CW'(HDR_LEN) && LW'(pos) == next_label_offset_next) begin
            if (item.data_byte == 8'd0) begin
              name_terminated_next = 1'b1;
              name_end_offset_next = pos + CW'(1);
              query_type_next      = '0;
            end else begin
              next_label_offset_next = LW'(pos) + LW'(item.data_byte) + LW'(1);
            end
          end
        end else if (pos == name_end_offset_next) begin
          query_type_next = {item.data_byte, query_type_next[7:0]};
        end else if (QW'(pos) == QW'(name_end_offset_next) + QW'(1)) begin
          query_type_next = {query_type_next[15:8], item.data_byte};
        end
      end

      if (item.op == OP_PUSH_LAST) begin
        qend_w = QW'(name_end_offset_next) + QW'(4);
        need   = qend_w + ((query_type_next == TYPE_A) ? QW'(ANS_LEN) : QW'(0));
        packet_verdict_next = VERDICT_DROP;
        question_end_next   = '0;
        if (byte_count_next >= CW'(HDR_LEN) && name_terminated_next &&
            qend_w <= QW'(byte_count_next) && need <= QW'(MAX_PACKET)) begin
          packet_verdict_next = VERDICT_READY;
          question_end_next   = CW'(qend_w);
        end
        byte_count_next        = '0;
        next_label_offset_next = LW'(HDR_LEN);
        name_terminated_next   = 1'b0;
        res.verdict = packet_verdict_next;
        if (packet_verdict_next == VERDICT_READY) begin
          res.reply_length = LEN_W'(need);
          res.is_a_answer  = (query_type_next == TYPE_A);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= item.data_byte;
    end
    mem_rdata <= mem[AW'(item.read_index)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      next_label_offset <= LW'(HDR_LEN);
      name_terminated   <= 1'b0;
      name_end_offset   <= '0;
      query_type        <= '0;
      packet_verdict    <= VERDICT_COLLECT;
      question_end      <= '0;
      done              <= 1'b0;
    end else begin
      byte_count        <= byte_count_next;
      next_label_offset <= next_label_offset_next;
      name_terminated   <= name_terminated_next;
      name_end_offset   <= name_end_offset_next;
      query_type        <= query_type_next;
      packet_verdict    <= packet_verdict_next;
      question_end      <= question_end_next;
      done              <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_q     <= res;
    sel_mem_q <= sel_mem;
  end

  always_comb begin
    response = res_q;
    if (sel_mem_q) begin
      response.reply_byte = mem_rdata;
    end
  end

  `DQAR_ASSERT_NEXT(a_pop_done, item_valid, done, "dequeued item gave no result")
  `DQAR_ASSERT_IMPL(a_drop_zero, done && response.verdict != VERDICT_READY,
    response.reply_length == '0 && !response.is_a_answer, "length or A flag without reply")
  `DQAR_ASSERT_IMPL(a_name_end, name_terminated, name_end_offset > CW'(HDR_LEN),
    "name terminator inside header")
  `DQAR_ASSERT_IMPL(a_count_range, 1'b1, byte_count <= CW'(MAX_PACKET),
    "byte count past buffer size")

endmodule
`default_nettype wire

// File: sv/dns_query_a_record_responder_core.sv
// Throughput: one command per cycle; a push and a read cost the same.
// A command passes through the queue and then the output register that lines up with the store read.
// The receiver cannot stall; busy stays low since the back end drains an entry every cycle.
// Synchronous active-high rst clears parse state, verdict and the address register.
`timescale 1ns / 1ps
`default_nettype none
module dns_query_a_record_responder_core
  import dqar_pkg::*;
#(
  parameter int MAX_PACKET = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire req_t        request,
  output logic             busy,
  output logic             done,
  output resp_t            response,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] answer_ipv4;
  logic        enq;
  cmd_t        enq_cmd;
  logic        queue_full;
  logic        queue_not_empty;
  logic        deq;
  cmd_t        head;

  assign cfg_ready = 1'b1;

  // Hold the answer address until the next transfer on the config channel
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_ipv4 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      answer_ipv4 <= cfg_data;
    end
  end

  dqar_front u_front (
    .start      (start),
    .request    (request),
    .queue_full (queue_full),
    .busy       (busy),
    .enq        (enq),
    .enq_cmd    (enq_cmd)
  );

  dqar_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_cmd   (enq_cmd),
    .deq       (deq),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  dqar_back #(
    .MAX_PACKET (MAX_PACKET)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (queue_not_empty),
    .item        (head),
    .item_pop    (deq),
    .answer_ipv4 (answer_ipv4),
    .done        (done),
    .response    (response)
  );

endmodule
`default_nettype wire

// File: bench/dqar_response_checker.sv
// Command codes for the bench and a checker that predicts and compares DNS responder results.
`timescale 1ns / 1ps

package dqar_bench_pkg;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;
endpackage

module dqar_response_checker
  import dqar_pkg::*;
  import dqar_bench_pkg::*;
#(
  parameter int MAX_PACKET = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        request,
  input  logic        done,
  input  resp_t       response,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          outstanding
);

  // Fixed bytes of the appended A answer.
  localparam logic [7:0] NAME_PTR_HI = 8'hC0;
  localparam logic [7:0] NAME_PTR_LO = 8'h0C;
  localparam logic [7:0] TTL_SECONDS = 8'h3C;
  localparam logic [7:0] ADDR_LEN    = 8'h04;

  logic [7:0]  query_bytes [MAX_PACKET];
  int unsigned stored_count;
  int unsigned label_at;
  int unsigned name_end;
  int unsigned question_end;
  bit          name_closed;
  logic [15:0] qtype;
  logic [1:0]  state_verdict;
  logic [31:0] answer_ip;

  resp_t pending_responses[$];
  int    errors = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] dqar mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
  endtask

  function automatic void restart_collect();
    stored_count = 0;
    label_at     = HDR_LEN;
    name_closed  = 1'b0;
  endfunction

  function automatic logic [LEN_W-1:0] reply_len();
    int unsigned n;
    if (state_verdict != VERDICT_READY) return '0;
    n = question_end + ((qtype == TYPE_A) ? ANS_LEN : 0);
    return LEN_W'(n);
  endfunction

  function automatic logic [7:0] reply_byte(input int unsigned idx);
    int unsigned k;
    if (state_verdict != VERDICT_READY || idx >= reply_len()) return 8'h00;
    if (idx < question_end) begin
      // Echo the question with flags and counts patched.
      case (idx)
        2:                 return FLAGS_HI;
        3:                 return FLAGS_LO;
        5:                 return 8'h01;
        7:                 return (qtype == TYPE_A) ? 8'h01 : 8'h00;
        4, 6, 8, 9, 10, 11: return 8'h00;
        default:           return query_bytes[idx];
      endcase
    end
    k = idx - question_end;
    case (k)
      0:              return NAME_PTR_HI;
      1:              return NAME_PTR_LO;
      3, 5:           return 8'h01;
      9:              return TTL_SECONDS;
      11:             return ADDR_LEN;
      12, 13, 14, 15: return answer_ip[8*(15-k) +: 8];
      default:        return 8'h00;
    endcase
  endfunction

  function automatic resp_t responder_outcome(input req_t cmd);
    resp_t       r;
    int unsigned pos;
    int unsigned qe;
    r = '0;
    if (cmd.command == CMD_READ) begin
      r.verdict      = state_verdict;
      r.reply_length = reply_len();
      r.reply_byte   = reply_byte(cmd.read_index);
      r.is_a_answer  = (state_verdict == VERDICT_READY && qtype == TYPE_A);
      return r;
    end
    // First push after a verdict opens a new query.
    if (state_verdict != VERDICT_COLLECT) begin
      state_verdict = VERDICT_COLLECT;
      question_end  = 0;
      qtype         = '0;
      name_end      = 0;
      restart_collect();
    end
    if (stored_count < MAX_PACKET) begin
      pos = stored_count;
      query_bytes[pos] = cmd.data_byte;
      stored_count = pos + 1;
      if (!name_closed) begin
        if (pos >= HDR_LEN && pos == label_at) begin
          if (cmd.data_byte == 8'h00) begin
            name_closed = 1'b1;
            name_end    = pos + 1;
            qtype       = '0;
          end else begin
            label_at = pos + cmd.data_byte + 1;
          end
        end
      end else if (pos == name_end) begin
        qtype[15:8] = cmd.data_byte;
      end else if (pos == name_end + 1) begin
        qtype[7:0] = cmd.data_byte;
      end
    end
    if (cmd.last) begin
      state_verdict = VERDICT_DROP;
      question_end  = 0;
      if (stored_count >= HDR_LEN && name_closed) begin
        qe = name_end + 4;
        if (qe <= stored_count && qe + ((qtype == TYPE_A) ? ANS_LEN : 0) <= MAX_PACKET) begin
          question_end  = qe;
          state_verdict = VERDICT_READY;
        end
      end
      restart_collect();
      r.verdict      = state_verdict;
      r.reply_length = reply_len();
      r.is_a_answer  = (state_verdict == VERDICT_READY && qtype == TYPE_A);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      restart_collect();
      name_end      = 0;
      question_end  = 0;
      qtype         = '0;
      state_verdict = VERDICT_COLLECT;
      answer_ip     = '0;
      pending_responses.delete();
    end else begin
      // Compare before queueing: a result never leaves in its own accept cycle.
      if (done) begin
        if (pending_responses.size() == 0) begin
          flag_mismatch($sformatf("unexpected result verdict %0d length %0d byte 0x%0h a %0b",
                                  response.verdict, response.reply_length,
                                  response.reply_byte, response.is_a_answer));
        end else begin
          want = pending_responses.pop_front();
          check_field("verdict", response.verdict, want.verdict);
          check_field("reply_length", response.reply_length, want.reply_length);
          check_field("reply_byte", response.reply_byte, want.reply_byte);
          check_field("is_a_answer", response.is_a_answer, want.is_a_answer);
        end
      end
      if (start && !busy) pending_responses.push_back(responder_outcome(request));
      if (cfg_valid && cfg_ready) answer_ip = cfg_data;
    end
    mismatch_count <= errors;
    outstanding    <= pending_responses.size();
  end

endmodule

// File: bench/tb_dns_query_a_record_responder_core.sv
// Stimulus and verdict for the DNS query A-record responder core.
`timescale 1ns / 1ps

module tb_dns_query_a_record_responder_core;
  import dqar_pkg::*;
  import dqar_bench_pkg::*;

  localparam int MAX_PACKET  = 512;
  localparam int ITEM_GOAL   = 2000;
  localparam int PHASES      = 6;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    Q_GOOD_A,
    Q_GOOD_OTHER,
    Q_TRUNC,
    Q_SHORT,
    Q_NO_TERM,
    Q_NOISE,
    Q_LONG_REPLY,
    Q_OVERSIZE
  } query_kind_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  req_t        request   = '0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        busy;
  logic        done;
  resp_t       response;
  logic        cfg_ready;
  int          mismatch_count;
  int          outstanding;

  int unsigned items_sent   = 0;
  int unsigned idle_pct     = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  query_buf[$];

  dns_query_a_record_responder_core #(
    .MAX_PACKET(MAX_PACKET)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .response(response),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  dqar_response_checker #(
    .MAX_PACKET(MAX_PACKET)
  ) reply_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .response(response),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    quiet_cycles <= ((start && !busy) || done || (cfg_valid && cfg_ready)) ? 0 : quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom);
  endfunction

  task automatic issue(input req_t r);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    req_t r;
    r.command    = CMD_PUSH;
    r.data_byte  = b;
    r.last       = fin;
    r.read_index = 9'($urandom);
    issue(r);
  endtask

  task automatic read_reply(input int unsigned idx);
    req_t r;
    r.command    = CMD_READ;
    r.data_byte  = rand_octet();
    r.last       = 1'($urandom);
    r.read_index = 9'(idx);
    issue(r);
  endtask

  task automatic write_address(input logic [31:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drop start and wait for every result to come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Append labels covering exactly span bytes (span must not be 1).
  task automatic add_name(input int unsigned span, input int unsigned max_label,
                          input bit closed);
    int unsigned left;
    int unsigned len;
    left = span;
    while (left > 0) begin
      len = $urandom_range(1, (left - 1 < max_label) ? left - 1 : max_label);
      // never leave a single byte, it cannot hold a label
      if (left - len - 1 == 1) len = (len > 1) ? len - 1 : len + 1;
      query_buf.push_back(8'(len));
      repeat (len) query_buf.push_back(rand_octet());
      left = left - len - 1;
    end
    if (closed) query_buf.push_back(8'h00);
  endtask

  task automatic add_qtype(input bit is_a);
    if (is_a) begin
      query_buf.push_back(TYPE_A[15:8]);
      query_buf.push_back(TYPE_A[7:0]);
    end else begin
      case ($urandom_range(0, 3))
        0: begin query_buf.push_back(8'h00); query_buf.push_back(8'h1C); end
        1: begin query_buf.push_back(8'h01); query_buf.push_back(8'h00); end
        2: begin query_buf.push_back(8'h00); query_buf.push_back(8'h00); end
        default: begin query_buf.push_back(rand_octet()); query_buf.push_back(rand_octet()); end
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      query_buf.push_back(rand_octet());
      query_buf.push_back(rand_octet());
    end else begin
      query_buf.push_back(8'h00);
      query_buf.push_back(8'h01);
    end
  endtask

  task automatic build_query(input query_kind_t kind);
    int unsigned span;
    int unsigned total;
    query_buf.delete();
    repeat (HDR_LEN) query_buf.push_back(rand_octet());
    span = $urandom_range(0, 40);
    if (span == 1) span = 0;
    case (kind)
      Q_GOOD_A, Q_GOOD_OTHER: begin
        add_name(span, 20, 1'b1);
        add_qtype(kind == Q_GOOD_A);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 11)) query_buf.push_back(rand_octet());
      end
      Q_TRUNC: begin
        // fewer than four bytes after the terminator
        add_name(span, 20, 1'b1);
        repeat ($urandom_range(0, 3)) query_buf.push_back(rand_octet());
      end
      Q_SHORT: begin
        query_buf.delete();
        repeat ($urandom_range(1, HDR_LEN - 1)) query_buf.push_back(rand_octet());
      end
      Q_NO_TERM: begin
        // last label points past the end of the query
        add_name(span, 20, 1'b0);
        query_buf.push_back(8'($urandom_range(8, 255)));
        repeat ($urandom_range(0, 6)) query_buf.push_back(rand_octet());
      end
      Q_NOISE: begin
        repeat ($urandom_range(1, 40)) query_buf.push_back(rand_octet());
      end
      Q_LONG_REPLY: begin
        // question ends at 493..512: an A answer fits only up to 496
        add_name($urandom_range(476, 495), 255, 1'b1);
        add_qtype($urandom_range(0, 3) != 0);
      end
      default: begin
        // overflow: the terminator may land past the buffer
        add_name($urandom_range(380, 520), 255, 1'b1);
        add_qtype(1'($urandom));
        total = $urandom_range(MAX_PACKET + 1, MAX_PACKET + 60);
        while (query_buf.size() < total) query_buf.push_back(rand_octet());
      end
    endcase
  endtask

  task automatic push_query();
    foreach (query_buf[i]) begin
      if ($urandom_range(0, 29) == 0) read_reply($urandom_range(0, 511));
      push_byte(query_buf[i], i == query_buf.size() - 1);
    end
  endtask

  task automatic read_back(input int unsigned qlen);
    int unsigned hi;
    hi = qlen + ANS_LEN + 2;
    if (hi > 511) hi = 511;
    if (qlen < 48 && $urandom_range(0, 7) == 0) begin
      for (int unsigned i = 0; i <= hi; i++) read_reply(i);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 9))
          0:       read_reply(511);
          1:       read_reply($urandom_range(0, HDR_LEN - 1));
          2:       read_reply($urandom_range(0, 511));
          default: read_reply($urandom_range(0, hi));
        endcase
      end
    end
  endtask

  function automatic query_kind_t pick_kind(input int unsigned qn);
    int unsigned roll;
    if (qn == 2) return Q_OVERSIZE;
    if (qn == 4) return Q_LONG_REPLY;
    roll = $urandom_range(0, 99);
    if (roll < 45) return Q_GOOD_A;
    if (roll < 60) return Q_GOOD_OTHER;
    if (roll < 70) return Q_TRUNC;
    if (roll < 77) return Q_SHORT;
    if (roll < 85) return Q_NO_TERM;
    if (roll < 93) return Q_NOISE;
    if (roll < 97) return Q_LONG_REPLY;
    return Q_OVERSIZE;
  endfunction

  initial begin
    int unsigned qn;
    int unsigned goal;
    qn = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_address(32'hFFFF_FFFF);

    // Reads before any query, then a short query that must drop.
    read_reply(0);
    read_reply(511);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    read_reply(2);
    // Smallest valid A query: root name, type A, class IN.
    for (int i = 0; i < HDR_LEN; i++) push_byte((i % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(TYPE_A[15:8], 1'b0);
    push_byte(TYPE_A[7:0], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    read_reply(2);
    read_reply(16);
    read_reply(32);
    read_reply(33);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_address((p == 0) ? 32'h0000_0000 : $urandom);
      // reread the held reply under the new address
      read_back(query_buf.size());
      if (p == PHASES - 1) idle_pct = 0;
      else if (p % 3 == 1) idle_pct = 12;
      else if (p % 3 == 2) idle_pct = 40;
      else idle_pct = 0;
      // phase goals are cumulative so long queries do not inflate the total
      goal = (p + 1) * ITEM_GOAL / PHASES;
      while (items_sent < goal) begin
        build_query(pick_kind(qn));
        push_query();
        read_back(query_buf.size());
        qn++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: dns_query_a_record_responder_core.f
+incdir+sv
sv/dqar_pkg.sv
sv/dqar_front.sv
sv/dqar_queue.sv
sv/dqar_back.sv
sv/dns_query_a_record_responder_core.sv
bench/dqar_response_checker.sv
bench/tb_dns_query_a_record_responder_core.sv
